// ===== hw/rtl/look_at_view_matrix_macros.svh =====
// ============================================================================
// Look-at view matrix: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ============================================================================
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// The condition implies the property in the same cycle.
`define LAVM_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The condition implies the property in the next cycle.
`define LAVM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/lavm_pkg.sv =====
// ============================================================================
// Look-at view matrix package
// Fixed-point widths, payload structs and register indexes shared by the
// view matrix pipeline.
// ============================================================================
package lavm_pkg;

    // Fraction bits of every fixed-point value.
    localparam int FRAC_BITS = 16;

    // Quotient bits of a normalize divide; a unit component is at most 1.0.
    localparam int QW = FRAC_BITS + 1;
    // Signed width of a unit vector component.
    localparam int VW = FRAC_BITS + 2;
    // Signed width of an exact cross product component.
    localparam int CW = FRAC_BITS + 34;
    // Signed width of an exact dot product.
    localparam int DW = FRAC_BITS + 36;
    // Width of the right-shift amount that brings a cross into 32 bits.
    localparam int SHW = $clog2(CW - 30);
    // Square root of a 64-bit sum: one result bit per stage.
    localparam int SQRT_STEPS = 32;
    // Partial remainder width of the square root.
    localparam int SRW = 35;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] REG_UP_X = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_UP_Y = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_UP_Z = CFG_AW'(2);

    // 1.0 in fixed point.
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef logic signed [31:0]   word_t;
    typedef logic signed [VW-1:0] unit_t;
    typedef logic signed [CW-1:0] crs_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec_t;

    typedef struct packed {
        unit_t x;
        unit_t y;
        unit_t z;
    } uvec_t;

    typedef struct packed {
        crs_t x;
        crs_t y;
        crs_t z;
    } cvec_t;

    // Values that ride along with an item through the pipeline.
    typedef struct packed {
        vec_t  pos;
        uvec_t f;
        uvec_t r;
    } side_t;

    // Input beat: one camera.
    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t face_x;
        word_t face_y;
        word_t face_z;
    } cam_t;

    // Output beat: the upper three rows of the view matrix.
    typedef struct packed {
        word_t right_x;
        word_t right_y;
        word_t right_z;
        word_t right_offset;
        word_t true_up_x;
        word_t true_up_y;
        word_t true_up_z;
        word_t up_offset;
        word_t back_x;
        word_t back_y;
        word_t back_z;
        word_t back_offset;
    } view_t;

endpackage

// ===== hw/rtl/lavm_norm.sv =====
// ============================================================================
// Vector normalize pipeline
// Sum of squares, a bit-per-stage square root and three bit-per-stage
// restoring divides give each component as sign * floor(|c| * 1.0 / n).
// ============================================================================
module lavm_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::vec_t  v,
    input  lavm_pkg::side_t side_in,
    output logic            out_valid,
    output lavm_pkg::uvec_t u,
    output lavm_pkg::side_t side_out
);
    import lavm_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        side_t            side;
    } ncar_t;

    logic [2:0][31:0] vin;
    assign vin = {v.x, v.y, v.z};

    // Magnitudes and their squares.
    logic             a_vld_reg;
    logic [2:0][63:0] a_sq_reg;
    logic [2:0][63:0] a_sq_next;
    ncar_t            a_car_reg;
    ncar_t            a_car_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_car_next.neg[i] = vin[i][31];
            a_car_next.mag[i] = vin[i][31] ? (32'd0 - vin[i]) : vin[i];
            a_sq_next[i]      = 64'(a_car_next.mag[i]) * 64'(a_car_next.mag[i]);
        end
        a_car_next.side = side_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sq_reg  <= a_sq_next;
            a_car_reg <= a_car_next;
        end
    end

    // Square root: the sum enters stage zero, one root bit per stage.
    logic             s_vld_reg  [0:SQRT_STEPS];
    logic [63:0]      s_rad_reg  [0:SQRT_STEPS];
    logic [SRW-1:0]   s_rem_reg  [0:SQRT_STEPS];
    logic [31:0]      s_root_reg [0:SQRT_STEPS];
    ncar_t            s_car_reg  [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg[0] <= 1'b0;
        else if (en)
            s_vld_reg[0] <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_rad_reg[0]  <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_car_reg[0]  <= a_car_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [SRW-1:0] cur;
        logic [SRW-1:0] trial;
        logic [SRW-1:0] rem_next;
        logic [31:0]    root_next;

        // Bring down two radicand bits and try the next root bit.
        always_comb
        begin
            cur   = {s_rem_reg[k][SRW-3:0], s_rad_reg[k][63:62]};
            trial = SRW'({s_root_reg[k], 2'b01});
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {s_root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {s_root_reg[k][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_vld_reg[k+1] <= 1'b0;
            else if (en)
                s_vld_reg[k+1] <= s_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_rad_reg[k+1]  <= {s_rad_reg[k][61:0], 2'b00};
                s_rem_reg[k+1]  <= rem_next;
                s_root_reg[k+1] <= root_next;
                s_car_reg[k+1]  <= s_car_reg[k];
            end
        end
    end

    // Divides: the root is the divisor of all three components.
    logic                     d_vld_reg [0:QW];
    logic [31:0]              d_n_reg   [0:QW];
    logic [2:0][32:0]         d_rem_reg [0:QW];
    logic [2:0][QW-1:0]       d_q_reg   [0:QW];
    ncar_t                    d_car_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg[0] <= 1'b0;
        else if (en)
            d_vld_reg[0] <= s_vld_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_n_reg[0] <= s_root_reg[SQRT_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                d_rem_reg[0][i] <= {1'b0, s_car_reg[SQRT_STEPS].mag[i]};
                d_q_reg[0][i]   <= '0;
            end
            d_car_reg[0] <= s_car_reg[SQRT_STEPS];
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [2:0][32:0]   rem_next;
        logic [2:0][QW-1:0] q_next;

        // One quotient bit per component; the remainder stays below the divisor.
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (d_rem_reg[j][i] >= {1'b0, d_n_reg[j]})
                begin
                    rem_next[i] = (d_rem_reg[j][i] - {1'b0, d_n_reg[j]}) << 1;
                    q_next[i]   = {d_q_reg[j][i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = d_rem_reg[j][i] << 1;
                    q_next[i]   = {d_q_reg[j][i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_vld_reg[j+1] <= 1'b0;
            else if (en)
                d_vld_reg[j+1] <= d_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_n_reg[j+1]   <= d_n_reg[j];
                d_rem_reg[j+1] <= rem_next;
                d_q_reg[j+1]   <= q_next;
                d_car_reg[j+1] <= d_car_reg[j];
            end
        end
    end

    // Apply signs; a zero-length vector gives zero.
    logic [2:0][VW-1:0] o_next;
    logic               o_vld_reg;
    uvec_t              o_u_reg;
    side_t              o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (d_n_reg[QW] == 32'd0)
                o_next[i] = '0;
            else if (d_car_reg[QW].neg[i])
                o_next[i] = VW'(0) - VW'(d_q_reg[QW][i]);
            else
                o_next[i] = VW'(d_q_reg[QW][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= d_vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_u_reg.x  <= unit_t'(o_next[2]);
            o_u_reg.y  <= unit_t'(o_next[1]);
            o_u_reg.z  <= unit_t'(o_next[0]);
            o_side_reg <= d_car_reg[QW].side;
        end
    end

    assign out_valid = o_vld_reg;
    assign u         = o_u_reg;
    assign side_out  = o_side_reg;

endmodule

// ===== hw/rtl/lavm_cross.sv =====
// ============================================================================
// Exact cross product
// Six products in the first stage, three differences in the second, kept at
// full width.
// ============================================================================
module lavm_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::uvec_t a,
    input  lavm_pkg::vec_t  b,
    input  lavm_pkg::side_t side_in,
    output logic            out_valid,
    output lavm_pkg::cvec_t c,
    output lavm_pkg::side_t side_out
);
    import lavm_pkg::*;

    // Partial products.
    logic               p_vld_reg;
    logic [5:0][CW-1:0] p_reg;
    logic [5:0][CW-1:0] p_next;
    side_t              p_side_reg;

    always_comb
    begin
        p_next[0] = CW'($signed(a.y) * $signed(b.z));
        p_next[1] = CW'($signed(a.z) * $signed(b.y));
        p_next[2] = CW'($signed(a.z) * $signed(b.x));
        p_next[3] = CW'($signed(a.x) * $signed(b.z));
        p_next[4] = CW'($signed(a.x) * $signed(b.y));
        p_next[5] = CW'($signed(a.y) * $signed(b.x));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg      <= p_next;
            p_side_reg <= side_in;
        end
    end

    // Differences.
    logic  c_vld_reg;
    cvec_t c_reg;
    side_t c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg.x    <= crs_t'(p_reg[0] - p_reg[1]);
            c_reg.y    <= crs_t'(p_reg[2] - p_reg[3]);
            c_reg.z    <= crs_t'(p_reg[4] - p_reg[5]);
            c_side_reg <= p_side_reg;
        end
    end

    assign out_valid = c_vld_reg;
    assign c         = c_reg;
    assign side_out  = c_side_reg;

endmodule

// ===== hw/rtl/lavm_scale.sv =====
// ============================================================================
// Cross product range reduction
// Finds the smallest floor right shift that brings all three components
// into 32-bit signed range, then applies it.
// ============================================================================
module lavm_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::cvec_t c,
    input  lavm_pkg::side_t side_in,
    output logic            out_valid,
    output lavm_pkg::vec_t  rs,
    output lavm_pkg::side_t side_out
);
    import lavm_pkg::*;

    // Shift search over the union of the magnitude bits.
    logic [CW-1:0]  orv;
    logic [SHW-1:0] sh_next;

    always_comb
    begin
        orv = (c.x ^ {CW{c.x[CW-1]}}) | (c.y ^ {CW{c.y[CW-1]}}) |
              (c.z ^ {CW{c.z[CW-1]}});
        sh_next = '0;
        for (int k = 32; k < CW; k++)
        begin
            if (orv[k-1])
                sh_next = SHW'(k - 31);
        end
    end

    logic           h_vld_reg;
    cvec_t          h_c_reg;
    logic [SHW-1:0] h_sh_reg;
    side_t          h_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (en)
            h_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_c_reg    <= c;
            h_sh_reg   <= sh_next;
            h_side_reg <= side_in;
        end
    end

    // Arithmetic shift; the result fits by construction.
    logic  r_vld_reg;
    vec_t  r_rs_reg;
    side_t r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_vld_reg <= 1'b0;
        else if (en)
            r_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_rs_reg.x <= word_t'($signed(h_c_reg.x) >>> h_sh_reg);
            r_rs_reg.y <= word_t'($signed(h_c_reg.y) >>> h_sh_reg);
            r_rs_reg.z <= word_t'($signed(h_c_reg.z) >>> h_sh_reg);
            r_side_reg <= h_side_reg;
        end
    end

    assign out_valid = r_vld_reg;
    assign rs        = r_rs_reg;
    assign side_out  = r_side_reg;

endmodule

// ===== hw/rtl/lavm_rows.sv =====
// ============================================================================
// Matrix row assembly
// Forms the true up and back axes, the three position dot products and the
// saturated negated offsets, and holds the finished rows.
// ============================================================================
module lavm_rows (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::cvec_t c,
    input  lavm_pkg::side_t side_in,
    output logic            out_valid,
    output lavm_pkg::view_t view
);
    import lavm_pkg::*;

    // Axes at 32 bits: true up floored to the fraction, back as minus forward.
    logic             x_vld_reg;
    logic [2:0][31:0] x_r_reg;
    logic [2:0][31:0] x_u_reg;
    logic [2:0][31:0] x_b_reg;
    logic [2:0][31:0] x_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_vld_reg <= 1'b0;
        else if (en)
            x_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_r_reg <= {word_t'($signed(side_in.r.x)), word_t'($signed(side_in.r.y)),
                        word_t'($signed(side_in.r.z))};
            x_u_reg <= {word_t'($signed(c.x) >>> FRAC_BITS),
                        word_t'($signed(c.y) >>> FRAC_BITS),
                        word_t'($signed(c.z) >>> FRAC_BITS)};
            x_b_reg <= {word_t'(-$signed(side_in.f.x)), word_t'(-$signed(side_in.f.y)),
                        word_t'(-$signed(side_in.f.z))};
            x_p_reg <= {side_in.pos.x, side_in.pos.y, side_in.pos.z};
        end
    end

    // Products of each axis with the position.
    logic               m_vld_reg;
    logic [2:0][DW-1:0] m_r_reg;
    logic [2:0][DW-1:0] m_u_reg;
    logic [2:0][DW-1:0] m_b_reg;
    logic [2:0][31:0]   m_ar_reg;
    logic [2:0][31:0]   m_au_reg;
    logic [2:0][31:0]   m_ab_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= x_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_r_reg[i] <= DW'($signed(x_r_reg[i]) * $signed(x_p_reg[i]));
                m_u_reg[i] <= DW'($signed(x_u_reg[i]) * $signed(x_p_reg[i]));
                m_b_reg[i] <= DW'($signed(x_b_reg[i]) * $signed(x_p_reg[i]));
            end
            m_ar_reg <= x_r_reg;
            m_au_reg <= x_u_reg;
            m_ab_reg <= x_b_reg;
        end
    end

    // Dot product sums, exact.
    logic               s_vld_reg;
    logic [2:0][DW-1:0] s_dot_reg;
    logic [2:0][31:0]   s_ar_reg;
    logic [2:0][31:0]   s_au_reg;
    logic [2:0][31:0]   s_ab_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else if (en)
            s_vld_reg <= m_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dot_reg[0] <= m_r_reg[0] + m_r_reg[1] + m_r_reg[2];
            s_dot_reg[1] <= m_u_reg[0] + m_u_reg[1] + m_u_reg[2];
            s_dot_reg[2] <= m_b_reg[0] + m_b_reg[1] + m_b_reg[2];
            s_ar_reg     <= m_ar_reg;
            s_au_reg     <= m_au_reg;
            s_ab_reg     <= m_ab_reg;
        end
    end

    // Floor to the fraction, negate and saturate to 32 bits.
    logic [2:0][31:0]   off_next;
    logic [2:0][DW-1:0] ng;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ng[i] = DW'(0) - DW'($signed(s_dot_reg[i]) >>> FRAC_BITS);
            if (ng[i][DW-1:31] == '0 || ng[i][DW-1:31] == '1)
                off_next[i] = ng[i][31:0];
            else if (ng[i][DW-1])
                off_next[i] = 32'h8000_0000;
            else
                off_next[i] = 32'h7fff_ffff;
        end
    end

    logic  o_vld_reg;
    view_t o_view_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else if (en)
            o_vld_reg <= s_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_view_reg.right_x      <= s_ar_reg[2];
            o_view_reg.right_y      <= s_ar_reg[1];
            o_view_reg.right_z      <= s_ar_reg[0];
            o_view_reg.right_offset <= off_next[0];
            o_view_reg.true_up_x    <= s_au_reg[2];
            o_view_reg.true_up_y    <= s_au_reg[1];
            o_view_reg.true_up_z    <= s_au_reg[0];
            o_view_reg.up_offset    <= off_next[1];
            o_view_reg.back_x       <= s_ab_reg[2];
            o_view_reg.back_y       <= s_ab_reg[1];
            o_view_reg.back_z       <= s_ab_reg[0];
            o_view_reg.back_offset  <= off_next[2];
        end
    end

    assign out_valid = o_vld_reg;
    assign view      = o_view_reg;

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
// ============================================================================
// Look-at view matrix
// World-to-camera matrix from a camera position, a facing direction and a
// configured up vector, in signed fixed point.
// ============================================================================
// The block takes one camera beat per clock while the pipeline advances and
// returns the three upper rows of its view matrix. Most of the pipeline lies
// in the two normalize units, each a 32-stage square root followed by a
// 17-stage divide. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stalled result holds every item in
// flight. The up vector registers reset to (0, 1.0, 0); the user must write
// them only while no camera is in flight, and the block does not enforce it.
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cam_valid,
    output logic                          cam_ready,
    input  lavm_pkg::cam_t                cam,
    output logic                          view_valid,
    input  logic                          view_ready,
    output lavm_pkg::view_t               view,
    input  logic                          cfg_we,
    input  logic [lavm_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [31:0]                   cfg_wdata
);
    import lavm_pkg::*;

    // Up vector registers.
    word_t up_x_reg;
    word_t up_y_reg;
    word_t up_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= ONE_Q;
            up_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_UP_X: up_x_reg <= cfg_wdata;
                REG_UP_Y: up_y_reg <= cfg_wdata;
                REG_UP_Z: up_z_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // Global advance: the output register is free or its beat is taken.
    logic en;
    assign en        = !view_valid || view_ready;
    assign cam_ready = en;

    // Forward vector.
    vec_t  face;
    side_t side0;
    logic  n1_vld;
    uvec_t n1_f;
    side_t n1_side;

    always_comb
    begin
        face.x    = cam.face_x;
        face.y    = cam.face_y;
        face.z    = cam.face_z;
        side0.pos = '{x: cam.pos_x, y: cam.pos_y, z: cam.pos_z};
        side0.f   = '0;
        side0.r   = '0;
    end

    lavm_norm u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cam_valid),
        .v        (face),
        .side_in  (side0),
        .out_valid(n1_vld),
        .u        (n1_f),
        .side_out (n1_side)
    );

    // Forward cross up.
    vec_t  up;
    side_t side1;
    logic  c1_vld;
    cvec_t c1;
    side_t c1_side;

    always_comb
    begin
        up.x  = up_x_reg;
        up.y  = up_y_reg;
        up.z  = up_z_reg;
        side1 = n1_side;
        side1.f = n1_f;
    end

    lavm_cross u_cross_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n1_vld),
        .a        (n1_f),
        .b        (up),
        .side_in  (side1),
        .out_valid(c1_vld),
        .c        (c1),
        .side_out (c1_side)
    );

    // Bring the cross into 32-bit range.
    logic  sc_vld;
    vec_t  sc_rs;
    side_t sc_side;

    lavm_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c1_vld),
        .c        (c1),
        .side_in  (c1_side),
        .out_valid(sc_vld),
        .rs       (sc_rs),
        .side_out (sc_side)
    );

    // Right vector.
    logic  n2_vld;
    uvec_t n2_r;
    side_t n2_side;

    lavm_norm u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sc_vld),
        .v        (sc_rs),
        .side_in  (sc_side),
        .out_valid(n2_vld),
        .u        (n2_r),
        .side_out (n2_side)
    );

    // Right cross forward.
    vec_t  fwd;
    side_t side2;
    logic  c2_vld;
    cvec_t c2;
    side_t c2_side;

    always_comb
    begin
        fwd.x   = word_t'($signed(n2_side.f.x));
        fwd.y   = word_t'($signed(n2_side.f.y));
        fwd.z   = word_t'($signed(n2_side.f.z));
        side2   = n2_side;
        side2.r = n2_r;
    end

    lavm_cross u_cross_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n2_vld),
        .a        (n2_r),
        .b        (fwd),
        .side_in  (side2),
        .out_valid(c2_vld),
        .c        (c2),
        .side_out (c2_side)
    );

    // Rows and offsets; the last stage is the output register.
    lavm_rows u_rows (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c2_vld),
        .c        (c2),
        .side_in  (c2_side),
        .out_valid(view_valid),
        .view     (view)
    );

    // A unit axis never exceeds 1.0 in magnitude.
    `LAVM_ASSERT_NOW(a_back_unit, view_valid,
        $signed(view.back_x) <= ONE_Q && $signed(view.back_x) >= -ONE_Q &&
        $signed(view.back_z) <= ONE_Q && $signed(view.back_z) >= -ONE_Q,
        "back axis exceeds unit length")
    `LAVM_ASSERT_NOW(a_right_unit, view_valid,
        $signed(view.right_x) <= ONE_Q && $signed(view.right_x) >= -ONE_Q &&
        $signed(view.right_y) <= ONE_Q && $signed(view.right_y) >= -ONE_Q,
        "right axis exceeds unit length")
    // A zero forward vector leaves every row zero.
    `LAVM_ASSERT_NOW(a_zero_fwd, view_valid && view.back_x == 0 && view.back_y == 0 &&
        view.back_z == 0,
        view.right_x == 0 && view.right_y == 0 && view.right_z == 0 &&
        view.true_up_x == 0 && view.true_up_y == 0 && view.true_up_z == 0 &&
        view.back_offset == 0,
        "zero forward vector gave a nonzero row")
    // A zero right vector forces a zero true up and zero offsets on both rows.
    `LAVM_ASSERT_NOW(a_zero_right, view_valid && view.right_x == 0 && view.right_y == 0 &&
        view.right_z == 0,
        view.true_up_x == 0 && view.true_up_y == 0 && view.true_up_z == 0 &&
        view.right_offset == 0 && view.up_offset == 0,
        "zero right vector gave a nonzero true up row")
    // A write to the up y register lands on the next edge.
    `LAVM_ASSERT_NEXT(a_cfg_up_y, cfg_we && cfg_addr == REG_UP_Y,
        up_y_reg == $past(cfg_wdata),
        "up y register missed a write")

endmodule
